FILE: src/assert_macros.svh
// assert_macros.svh: assertion macros for the checker module olve_chk.
// No dependencies; every macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/olve_pkg.sv
// olve_pkg: types and constants of the ordered value list engine.
// No dependencies; used by every module of the block.
package olve_pkg;

    localparam int CNT_W = 7;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;

    // command codes
    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_FIND      = 3'd1;
    localparam logic [2:0] CMD_DEL_FIRST = 3'd2;
    localparam logic [2:0] CMD_DEL_ALL   = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]              command;
        logic signed [VAL_W-1:0] item_value;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] length_after;
        logic             last_result;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_en;
        logic fin;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

FILE: src/olve_ctrl.sv
// olve_ctrl: command sequencer of the list engine.
// Depends on olve_pkg for command codes and the control/status structs.
module olve_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [2:0]        i_command,
    input  olve_pkg::t_sts    i_sts,
    output olve_pkg::t_ctl    o_ctl,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   w_accept;
    logic   w_scan_cmd;

    assign w_accept   = start && !r_busy;
    assign w_scan_cmd = (i_command == olve_pkg::CMD_FIND) ||
                        (i_command == olve_pkg::CMD_DEL_FIRST) ||
                        (i_command == olve_pkg::CMD_DEL_ALL);

    // next state
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_busy  = 1'b1;
                    n_state = w_scan_cmd ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    // datapath commands
    always_comb begin
        o_ctl         = '0;
        o_ctl.load    = w_accept;
        o_ctl.scan_en = (r_state == S_SCAN);
        o_ctl.fin     = (r_state == S_FIN);
    end

    assign busy = r_busy;

endmodule

FILE: src/olve_dpath.sv
// olve_dpath: entry store, scan pipeline, compaction and result register.
// Depends on olve_pkg for field types, codes and the control/status structs.
module olve_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  olve_pkg::t_item      i_item,
    input  olve_pkg::t_ctl       i_ctl,
    output olve_pkg::t_sts       o_sts,
    output olve_pkg::t_result    o_result,
    output logic                 o_strobe
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [olve_pkg::CNT_W-1:0] CAP_CNT = olve_pkg::CNT_W'(CAPACITY);

    logic [olve_pkg::VAL_W-1:0] mem [CAPACITY];

    // latched command
    logic [2:0]                  r_cmd;
    logic [olve_pkg::VAL_W-1:0]  r_key;
    // list length and scan pointers
    logic [olve_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [olve_pkg::CNT_W-1:0]  r_rd;
    logic [olve_pkg::CNT_W-1:0]  r_wr, n_wr;
    logic [olve_pkg::CNT_W-1:0]  r_removed, n_removed;
    // read stage
    logic [olve_pkg::VAL_W-1:0]  r_q;
    logic                        r_q_vld;
    logic [AW-1:0]               r_q_idx;
    // held find match
    logic                        r_pend_vld, n_pend_vld;
    logic [AW-1:0]               r_pend_pos, n_pend_pos;
    // result register
    olve_pkg::t_result           r_out, n_out;
    logic                        r_out_vld, n_out_vld;

    logic          w_rd_en;
    logic          w_is_find;
    logic          w_is_del;
    logic          w_match;
    logic          w_drop;
    logic          w_full;
    logic          w_we;
    logic [AW-1:0] w_waddr;

    assign w_is_find = (r_cmd == olve_pkg::CMD_FIND);
    assign w_is_del  = (r_cmd == olve_pkg::CMD_DEL_FIRST) ||
                       (r_cmd == olve_pkg::CMD_DEL_ALL);
    assign w_full    = (r_cnt >= CAP_CNT);
    assign w_rd_en   = i_ctl.scan_en && (r_rd < r_cnt);
    assign w_match   = r_q_vld && (r_q == r_key);
    assign w_drop    = w_match && ((r_cmd == olve_pkg::CMD_DEL_ALL) || (r_removed == '0));

    // single write port: kept entries during compaction, or the tail on append
    assign w_we    = (r_q_vld && w_is_del && !w_drop) ||
                     (i_ctl.fin && (r_cmd == olve_pkg::CMD_APPEND) && !w_full);
    assign w_waddr = i_ctl.fin ? r_cnt[AW-1:0] : r_wr[AW-1:0];

    assign o_sts.scan_done = (r_rd >= r_cnt) && !r_q_vld;

    // compare stage and final result
    always_comb begin
        n_cnt      = r_cnt;
        n_wr       = r_wr;
        n_removed  = r_removed;
        n_pend_vld = r_pend_vld;
        n_pend_pos = r_pend_pos;
        n_out      = r_out;
        n_out_vld  = 1'b0;

        if (r_q_vld && w_is_del) begin
            if (w_drop) begin
                n_removed = r_removed + 1'b1;
            end else begin
                n_wr = r_wr + 1'b1;
            end
        end

        // a new match releases the previous one as a non-final result
        if (w_match && w_is_find) begin
            if (r_pend_vld) begin
                n_out_vld           = 1'b1;
                n_out.status        = olve_pkg::ST_DONE;
                n_out.position      = olve_pkg::POS_W'(r_pend_pos);
                n_out.removed_count = '0;
                n_out.length_after  = r_cnt;
                n_out.last_result   = 1'b0;
            end
            n_pend_vld = 1'b1;
            n_pend_pos = r_q_idx;
        end

        if (i_ctl.fin) begin
            n_out_vld           = 1'b1;
            n_out.status        = olve_pkg::ST_DONE;
            n_out.position      = '0;
            n_out.removed_count = '0;
            n_out.length_after  = r_cnt;
            n_out.last_result   = 1'b1;
            case (r_cmd)
                olve_pkg::CMD_APPEND: begin
                    if (w_full) begin
                        n_out.status = olve_pkg::ST_FULL;
                    end else begin
                        n_cnt              = r_cnt + 1'b1;
                        n_out.length_after = r_cnt + 1'b1;
                    end
                end
                olve_pkg::CMD_FIND: begin
                    if (r_pend_vld) begin
                        n_out.position = olve_pkg::POS_W'(r_pend_pos);
                    end else begin
                        n_out.status = olve_pkg::ST_NOT_FOUND;
                    end
                end
                olve_pkg::CMD_DEL_FIRST, olve_pkg::CMD_DEL_ALL: begin
                    n_cnt               = r_wr;
                    n_out.length_after  = r_wr;
                    n_out.removed_count = r_removed;
                    if (r_removed == '0) begin
                        n_out.status = olve_pkg::ST_NOT_FOUND;
                    end
                end
                olve_pkg::CMD_CLEAR: begin
                    n_cnt              = '0;
                    n_out.length_after = '0;
                end
                default: begin
                    n_out.status = olve_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    // entry store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_ctl.fin ? r_key : r_q;
        end
        if (w_rd_en) begin
            r_q <= mem[r_rd[AW-1:0]];
        end
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_q_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_rd       <= '0;
            r_wr       <= '0;
            r_removed  <= '0;
        end else begin
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            r_out     <= n_out;
            r_q_vld   <= w_rd_en;
            if (w_rd_en) begin
                r_q_idx <= r_rd[AW-1:0];
                r_rd    <= r_rd + 1'b1;
            end
            if (i_ctl.load) begin
                r_cmd      <= i_item.command;
                r_key      <= i_item.item_value;
                r_rd       <= '0;
                r_wr       <= '0;
                r_removed  <= '0;
                r_pend_vld <= 1'b0;
            end else begin
                r_wr       <= n_wr;
                r_removed  <= n_removed;
                r_pend_vld <= n_pend_vld;
                r_pend_pos <= n_pend_pos;
            end
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_out_vld;

endmodule

FILE: src/ordered_value_list_engine_top.sv
// ordered_value_list_engine_top: ordered list of signed 32-bit values.
// Depends on olve_pkg, olve_ctrl and olve_dpath.
//
//  channel   ports                 handshake
//  command   i_item                taken when start && !busy
//  result    o_result              one cycle, marked by o_strobe
//
// Append, clear and unknown commands go from idle straight to the finish state.
// Find and delete read one entry per cycle through the store's single read port
// before the finish state, which computes the final result for the result register.
// Earlier find results appear during the scan; every final result comes in the
// first cycle after busy falls. Reset empties the list at once, no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ordered_value_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  olve_pkg::t_item     i_item,
    output logic                busy,
    output olve_pkg::t_result   o_result,
    output logic                o_strobe
);

    olve_pkg::t_ctl w_ctl;
    olve_pkg::t_sts w_sts;

    olve_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_item.command),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl),
        .busy      (busy)
    );

    olve_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

FILE: src/olve_chk.sv
// olve_chk: port-level checks of the list engine, bound to the top level.
// Depends on olve_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olve_chk #(
    parameter int CAPACITY = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input olve_pkg::t_result o_result,
    input logic              o_strobe
);

    // an accepted transaction keeps the block busy next cycle
    `AST_NEXT(a_busy_after_accept, start && !busy, busy, "busy did not rise after accept")

    // the final result of a transaction comes once the block is idle
    `AST_NOW(a_last_when_idle, o_strobe && o_result.last_result, !busy, "last result while busy")

    // earlier find results come only during the scan
    `AST_NOW(a_mid_when_busy, o_strobe && !o_result.last_result, busy && o_result.status == olve_pkg::ST_DONE, "intermediate result outside scan")

    // a full list reports exactly the capacity
    `AST_NOW(a_full_len, o_strobe && o_result.status == olve_pkg::ST_FULL, o_result.length_after == olve_pkg::CNT_W'(CAPACITY), "full status with wrong length")

    // nothing found means nothing removed
    `AST_NOW(a_nf_removed, o_strobe && o_result.status == olve_pkg::ST_NOT_FOUND, o_result.removed_count == '0 && o_result.position == '0, "not found with removals or position")

endmodule

bind ordered_value_list_engine_top olve_chk #(
    .CAPACITY (CAPACITY)
) u_olve_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);
